/* hdl/csdm_pkg.sv */
`timescale 1ns / 1ps
package csdm_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam int LEAVES     = 1 << $clog2(DATA_WIDTH);
	localparam int LEVELS     = $clog2(LEAVES);
	localparam int STAGES     = LEVELS + 2;
	localparam int S_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int M_FIELDS_W = PROD_WIDTH + 2 * DATA_WIDTH;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

/* hdl/csd_constant_multiplier.sv */
`timescale 1ns / 1ps
// Multiplies a stream of signed operands by a signed constant held in a
// configuration register, using the canonical signed digit form of the constant.
// The constant is to be written through cfg_we and cfg_data only while no
// transfer is in flight; the block itself does not enforce this. Its digit
// masks are registered from the stored constant.
// Each slave-side transfer carries one operand, and each master-side transfer
// carries the exact double-width product with the plus and minus digit masks.
// One operand may be accepted in every cycle unless a receiver stall has backed
// up to the input stage. The result of an operand reaches the master side after
// one input stage, one stage that forms the shifted and signed partial products,
// and four adder tree levels, so the latency follows the depth of the adder tree.
// When the receiver stalls, the stalled stage and the unbroken run of full stages
// behind it hold, while empty stages further up keep filling, so nothing is lost
// or repeated. Reset empties the pipeline and clears the constant and its masks
// to zero.
module csd_constant_multiplier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csdm_pkg::DATA_WIDTH-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Fields from bit 0: multiplicand.
	input  logic [csdm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Fields from bit 0: product, plus_digits, minus_digits.
	output logic [csdm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	localparam int W  = csdm_pkg::DATA_WIDTH;
	localparam int PW = csdm_pkg::PROD_WIDTH;
	localparam int NL = csdm_pkg::LEAVES;
	localparam int NS = csdm_pkg::STAGES;

	logic signed [W-1:0]  cst_q;
	logic [W-1:0]         plus_q;
	logic [W-1:0]         minus_q;
	logic [W-1:0]         mag;
	logic [W+1:0]         triple;
	logic [W+1:0]         diff;
	logic [W-1:0]         pos_dig;
	logic [W-1:0]         neg_dig;

	logic [NS-1:0]        vld_s;
	logic [NS-1:0]        en;
	logic signed [W-1:0]  mcand_s1;
	logic signed [PW-1:0] mext;
	logic signed [PW-1:0] node_s [1:2*NL-1];

	always_comb begin
		mag     = cst_q[W-1] ? (W'(0) - cst_q) : cst_q;
		triple  = {2'b00, mag} + {1'b0, mag, 1'b0};
		diff    = triple ^ {2'b00, mag};
		pos_dig = diff[W:1] & triple[W:1];
		neg_dig = diff[W:1] & {1'b0, mag[W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q   <= '0;
			plus_q  <= '0;
			minus_q <= '0;
		end else begin
			if (cfg_we) begin
				cst_q <= cfg_data;
			end
			plus_q  <= cst_q[W-1] ? neg_dig : pos_dig;
			minus_q <= cst_q[W-1] ? pos_dig : neg_dig;
		end
	end

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || m_axis_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && s_axis_tvalid) begin
			mcand_s1 <= s_axis_tdata[W-1:0];
		end
	end

	assign mext = {{W{mcand_s1[W-1]}}, mcand_s1};

	for (genvar gi = 0; gi < NL; gi++) begin : g_leaf
		if (gi < W) begin : g_term
			always_ff @(posedge clk) begin
				if (en[1]) begin
					if (plus_q[gi]) begin
						node_s[NL+gi] <= mext <<< gi;
					end else if (minus_q[gi]) begin
						node_s[NL+gi] <= -(mext <<< gi);
					end else begin
						node_s[NL+gi] <= '0;
					end
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				node_s[NL+gi] <= '0;
			end
		end
	end

	for (genvar gn = 1; gn < NL; gn++) begin : g_node
		localparam int STG = 1 + csdm_pkg::LEVELS - ($clog2(gn + 1) - 1);
		always_ff @(posedge clk) begin
			if (en[STG]) begin
				node_s[gn] <= node_s[2*gn] + node_s[2*gn+1];
			end
		end
	end

	assign m_axis_tvalid = vld_s[NS-1];
	assign m_axis_tdata  = csdm_pkg::M_TDATA_W'({minus_q, plus_q, node_s[1]});

endmodule

/* hdl/csdm_checker.sv */
`timescale 1ns / 1ps
module csdm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [csdm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	localparam int W  = csdm_pkg::DATA_WIDTH;
	localparam int PW = csdm_pkg::PROD_WIDTH;

	logic [PW-1:0] prod;
	logic [W-1:0]  plus_d;
	logic [W-1:0]  minus_d;
	logic [W-1:0]  any_d;

	assign prod    = m_axis_tdata[PW-1:0];
	assign plus_d  = m_axis_tdata[PW+W-1:PW];
	assign minus_d = m_axis_tdata[PW+2*W-1:PW+W];
	assign any_d   = plus_d | minus_d;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result changed before its transfer.");

	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (plus_d & minus_d) == '0)
		else $error("A digit is marked both plus and minus.");

	a_nonadjacent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (any_d & (any_d >> 1)) == '0)
		else $error("Two adjacent nonzero digits in the recoded constant.");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && any_d == '0 |-> prod == '0)
		else $error("Nonzero product for a zero constant.");

endmodule

bind csd_constant_multiplier csdm_checker u_csdm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_csd_constant_multiplier.sv */
`timescale 1ns / 1ps
module tb_csd_constant_multiplier;

	localparam int DATA_WIDTH       = csdm_pkg::DATA_WIDTH;
	localparam int PROD_WIDTH       = csdm_pkg::PROD_WIDTH;
	localparam int S_TDATA_W        = csdm_pkg::S_TDATA_W;
	localparam int M_TDATA_W        = csdm_pkg::M_TDATA_W;
	localparam int STAGES           = csdm_pkg::STAGES;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS      = 125;

	typedef struct packed {
		logic [PROD_WIDTH-1:0] product;
		logic [DATA_WIDTH-1:0] plus_digits;
		logic [DATA_WIDTH-1:0] minus_digits;
	} csd_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [DATA_WIDTH-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;

	logic [DATA_WIDTH-1:0]  operand_q[$];
	csd_result_t            csd_result_q[$];
	logic [DATA_WIDTH-1:0]  plus_shadow = '0;
	logic [DATA_WIDTH-1:0]  minus_shadow = '0;
	int                     send_idle_pct = 0;
	int                     recv_stall_pct = 0;
	int                     hold_req_count = 0;
	int                     hold_seen_count = 0;
	int                     hold_left = 0;
	int                     mismatch_count = 0;

	csd_constant_multiplier i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** csd_constant_multiplier: FAILED **");
		$finish;
	end

	function automatic void recode_constant(input logic [DATA_WIDTH-1:0] value,
			output logic [DATA_WIDTH-1:0] plus_d, output logic [DATA_WIDTH-1:0] minus_d);
		logic                  neg;
		logic [DATA_WIDTH-1:0] mag;
		logic                  prev;
		logic                  gam;
		logic                  xnext;
		neg = value[DATA_WIDTH-1];
		mag = neg ? -value : value;
		plus_d = '0;
		minus_d = '0;
		prev = 1'b0;
		gam = 1'b0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			xnext = (i + 1 < DATA_WIDTH) ? mag[i+1] : 1'b0;
			gam = !gam & (mag[i] ^ prev);
			if (gam) begin
				if (xnext == neg)
					plus_d[i] = 1'b1;
				else
					minus_d[i] = 1'b1;
			end
			prev = mag[i];
		end
	endfunction

	function automatic csd_result_t csd_multiply(input logic [DATA_WIDTH-1:0] operand);
		csd_result_t           res;
		logic [PROD_WIDTH-1:0] ext;
		logic [PROD_WIDTH-1:0] acc;
		ext = {{DATA_WIDTH{operand[DATA_WIDTH-1]}}, operand};
		acc = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (plus_shadow[i])
				acc = acc + (ext << i);
			else if (minus_shadow[i])
				acc = acc - (ext << i);
		end
		res.product = acc;
		res.plus_digits = plus_shadow;
		res.minus_digits = minus_shadow;
		return res;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] random_operand();
		case ($urandom_range(7))
			0: return '0;
			1: return {{(DATA_WIDTH-1){1'b0}}, 1'b1};
			2: return '1;
			3: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			4: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// Driver: a transfer completes when tvalid and tready are both high at an edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				csd_result_q.push_back(csd_multiply(s_axis_tdata[DATA_WIDTH-1:0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (operand_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tdata <= S_TDATA_W'(operand_q.pop_front());
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready, with an occasional long hold-off requested by the stimulus.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen_count != hold_req_count) begin
			m_axis_tready <= 1'b0;
			hold_seen_count <= hold_req_count;
			hold_left <= LONG_HOLD_CYCLES;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: each result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		csd_result_t want;
		csd_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = csd_result_t'({m_axis_tdata[PROD_WIDTH+DATA_WIDTH +: DATA_WIDTH],
				m_axis_tdata[PROD_WIDTH +: DATA_WIDTH], m_axis_tdata[PROD_WIDTH-1:0]});
			got.product = m_axis_tdata[PROD_WIDTH-1:0];
			got.plus_digits = m_axis_tdata[PROD_WIDTH +: DATA_WIDTH];
			got.minus_digits = m_axis_tdata[PROD_WIDTH+DATA_WIDTH +: DATA_WIDTH];
			if (csd_result_q.size() == 0) begin
				$error("Result transfer with no expected result: product %0d",
					$signed(got.product));
				mismatch_count++;
			end else begin
				want = csd_result_q.pop_front();
				if (got.product !== want.product) begin
					$error("product: expected %0d, actual %0d", $signed(want.product),
						$signed(got.product));
					mismatch_count++;
				end
				if (got.plus_digits !== want.plus_digits) begin
					$error("plus_digits: expected %h, actual %h", want.plus_digits,
						got.plus_digits);
					mismatch_count++;
				end
				if (got.minus_digits !== want.minus_digits) begin
					$error("minus_digits: expected %h, actual %h", want.minus_digits,
						got.minus_digits);
					mismatch_count++;
				end
			end
		end
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (operand_q.size() != 0 || s_axis_tvalid || csd_result_q.size() != 0);
	endtask

	task automatic write_constant(input logic [DATA_WIDTH-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		recode_constant(value, plus_shadow, minus_shadow);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_directed();
		operand_q.push_back('0);
		operand_q.push_back({{(DATA_WIDTH-1){1'b0}}, 1'b1});
		operand_q.push_back('1);
		operand_q.push_back({1'b0, {(DATA_WIDTH-1){1'b1}}});
		operand_q.push_back({1'b1, {(DATA_WIDTH-1){1'b0}}});
		operand_q.push_back(DATA_WIDTH'($urandom));
	endtask

	task automatic run_random_phase(input logic [DATA_WIDTH-1:0] value, input int send_pct,
			input int stall_pct);
		write_constant(value);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		repeat (PHASE_ITEMS) operand_q.push_back(random_operand());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// The reset constant is zero, so the first operands must give zero products.
		push_directed();
		write_constant({1'b1, {(DATA_WIDTH-1){1'b0}}});
		push_directed();
		write_constant({1'b0, {(DATA_WIDTH-1){1'b1}}});
		push_directed();
		write_constant('1);
		push_directed();

		run_random_phase({1'b0, {(DATA_WIDTH-1){1'b1}}}, 0, 0);
		hold_req_count++;
		run_random_phase({1'b1, {(DATA_WIDTH-1){1'b0}}}, 72, 0);
		run_random_phase(DATA_WIDTH'($urandom), 0, 72);
		run_random_phase({(DATA_WIDTH/2){2'b01}}, 24, 24);

		// Pause the sender in the middle of a phase until every result is back.
		write_constant({(DATA_WIDTH/2){2'b10}});
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (PHASE_ITEMS / 2) operand_q.push_back(random_operand());
		wait_drained();
		repeat (PHASE_ITEMS / 2) operand_q.push_back(random_operand());

		run_random_phase({{(DATA_WIDTH-1){1'b0}}, 1'b1}, 72, 72);
		run_random_phase(DATA_WIDTH'($urandom), 24, 24);
		run_random_phase('0, 0, 72);
		run_random_phase(DATA_WIDTH'($urandom), 72, 0);

		wait_drained();
		repeat (4 * STAGES) @(posedge clk);
		if (mismatch_count == 0 && csd_result_q.size() == 0) begin
			$display("** csd_constant_multiplier: PASSED **");
		end else begin
			$display("** csd_constant_multiplier: FAILED **");
		end
		$finish;
	end

endmodule
